FILE: rtl/pms_pkg.sv
package pms_pkg;

  // field widths
  localparam int RAW_W  = 16;
  localparam int GAIN_W = 10;
  localparam int DPI_W  = 15;
  localparam int REM_W  = 24;
  localparam int OUT_W  = 32;
  localparam int STAT_W = 3;

  // configuration port
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = DPI_W;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DPI  = 2'd1;

  // scaling constants
  localparam int REFERENCE_DPI = 1000;
  localparam int MIN_GAIN      = 1;
  localparam int MAX_GAIN      = 1000;
  localparam int MIN_DPI       = 100;
  localparam int MAX_DPI       = 32000;
  localparam int MAX_MOTION    = 32767;
  localparam int DPI_SCALE     = 100;
  localparam logic [GAIN_W-1:0] GAIN_RESET = 10'd100;

  // datapath widths: |raw| * gain * REFERENCE_DPI + remainder stays below 2^35
  localparam int MULT_W = 20;
  localparam int ACC_W  = 36;
  localparam int NUM_W  = ACC_W + 1;
  localparam int MAG_W  = ACC_W;
  localparam int DIV_W  = 22;

  localparam int MUL_STEPS = RAW_W;
  localparam int DIV_STEPS = MAG_W;

  localparam logic signed [NUM_W-1:0] MOTION_HI = NUM_W'(MAX_MOTION);
  localparam logic signed [NUM_W-1:0] MOTION_LO = -NUM_W'(MAX_MOTION);

  typedef enum logic [STAT_W-1:0] {
    STAT_MOTION  = 3'd0,
    STAT_ZERO    = 3'd1,
    STAT_BADCAL  = 3'd2,
    STAT_RANGE   = 3'd3,
    STAT_INVALID = 3'd4
  } pms_status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } pms_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } pms_unit_sts_t;

endpackage

FILE: rtl/pms_if.sv
interface pms_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [pms_pkg::RAW_W-1:0]  raw_dx;
  logic signed [pms_pkg::RAW_W-1:0]  raw_dy;

  modport source (output valid, output raw_dx, output raw_dy, input ready);
  modport sink   (input valid, input raw_dx, input raw_dy, output ready);
endinterface

interface pms_out_if;
  logic                              valid;
  logic                              ready;
  logic [pms_pkg::STAT_W-1:0]        status;
  logic signed [pms_pkg::OUT_W-1:0]  scaled_dx;
  logic signed [pms_pkg::OUT_W-1:0]  scaled_dy;

  modport source (output valid, output status, output scaled_dx, output scaled_dy,
                  input ready);
  modport sink   (input valid, input status, input scaled_dx, input scaled_dy,
                  output ready);
endinterface

FILE: rtl/pointer_motion_scaler.sv
// Pointer motion scaler: scales a raw relative mouse delta pair by the
// pointer gain and the source resolution, carrying the division remainder
// of each axis from one report to the next.
// Channels: in_ch takes a request of raw_dx/raw_dy (16-bit signed); out_ch
// returns one request per input with status, scaled_dx and scaled_dy (the
// deltas are zero unless status is motion). Both use valid/ready.
// Configuration: cfg_we/cfg_index/cfg_wdata write gain_percent (index 0) and
// source_dpi (index 1); other indexes are dropped. Write only while idle.
// Sequence: a calibrated request passes through the bit-serial multiplier
// (16 shift-add steps over the raw count plus the remainder add), then the
// restoring divider, one quotient bit a cycle, then the done state that
// loads the output register. A bad calibration goes from idle straight to
// the done state, with the remainders left as they are.
// Flow: in_ch.ready is high only while idle, so a new request is not taken
// until the last one is finished. A finished result waits in the output
// register, so the next request is taken while the receiver stalls; a second
// finished result then holds until the first is taken.
// Reset: gain_percent returns to 100, source_dpi to 0, both remainders to
// zero and the output register empties.
module pointer_motion_scaler (
  input  logic                                 clk,
  input  logic                                 rst_n,
  pms_in_if.sink                               in_ch,
  pms_out_if.source                            out_ch,
  input  logic                                 cfg_we,
  input  logic [pms_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [pms_pkg::CFG_W-1:0]            cfg_wdata
);

  // configuration registers
  logic [pms_pkg::GAIN_W-1:0] gain_r;
  logic [pms_pkg::DPI_W-1:0]  dpi_r;

  // sequencer and carried state
  pms_pkg::pms_state_t          state_r, state_nxt;
  logic                         badcal_r;
  logic [pms_pkg::DIV_W-1:0]    divisor_r;
  logic signed [pms_pkg::REM_W-1:0] rem_x_r;
  logic signed [pms_pkg::REM_W-1:0] rem_y_r;

  // output register
  logic                             ovalid_r;
  logic [pms_pkg::STAT_W-1:0]       ostatus_r;
  logic signed [pms_pkg::OUT_W-1:0] odx_r;
  logic signed [pms_pkg::OUT_W-1:0] ody_r;

  logic                             accept;
  logic                             cal_ok;
  logic [pms_pkg::MULT_W-1:0]       mult;
  logic [pms_pkg::DIV_W-1:0]        divisor;
  logic                             start_mul;
  logic                             start_div;
  logic                             load_out;
  logic                             in_ready;

  logic signed [pms_pkg::NUM_W-1:0] num_x, num_y;
  logic signed [pms_pkg::NUM_W-1:0] quot_x, quot_y;
  logic signed [pms_pkg::REM_W-1:0] rem_x, rem_y;
  pms_pkg::pms_unit_sts_t           mul_x_sts, mul_y_sts, div_x_sts, div_y_sts;

  pms_pkg::pms_status_t             status;
  logic                             fit_x, fit_y, zero_xy, mot_x, mot_y;

  // config writes, masked to register width
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= pms_pkg::GAIN_RESET;
      dpi_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pms_pkg::CFG_GAIN: gain_r <= cfg_wdata[pms_pkg::GAIN_W-1:0];
        pms_pkg::CFG_DPI:  dpi_r  <= cfg_wdata[pms_pkg::DPI_W-1:0];
        default: ;
      endcase
    end
  end

  assign cal_ok = (gain_r >= pms_pkg::GAIN_W'(pms_pkg::MIN_GAIN)) &&
                  (gain_r <= pms_pkg::GAIN_W'(pms_pkg::MAX_GAIN)) &&
                  ((dpi_r == '0) ||
                   ((dpi_r >= pms_pkg::DPI_W'(pms_pkg::MIN_DPI)) &&
                    (dpi_r <= pms_pkg::DPI_W'(pms_pkg::MAX_DPI))));

  // without a source resolution, no normalisation: factor 1, divisor 100
  assign mult    = (dpi_r == '0) ? pms_pkg::MULT_W'(gain_r)
                                 : pms_pkg::MULT_W'(32'(gain_r) * 32'(pms_pkg::REFERENCE_DPI));
  assign divisor = (dpi_r == '0) ? pms_pkg::DIV_W'(pms_pkg::DPI_SCALE)
                                 : pms_pkg::DIV_W'(32'(dpi_r) * 32'(pms_pkg::DPI_SCALE));

  assign accept = in_ch.valid && in_ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pms_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = cal_ok ? pms_pkg::ST_MUL : pms_pkg::ST_DONE;
        end
      end
      pms_pkg::ST_MUL: begin
        if (mul_x_sts.done && mul_y_sts.done) begin
          state_nxt = pms_pkg::ST_DIV;
        end
      end
      pms_pkg::ST_DIV: begin
        if (div_x_sts.done && div_y_sts.done) begin
          state_nxt = pms_pkg::ST_DONE;
        end
      end
      pms_pkg::ST_DONE: begin
        if (!ovalid_r || out_ch.ready) begin
          state_nxt = pms_pkg::ST_IDLE;
        end
      end
      default: state_nxt = pms_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready  = 1'b0;
    start_mul = 1'b0;
    start_div = 1'b0;
    load_out  = 1'b0;
    unique case (state_r)
      pms_pkg::ST_IDLE: begin
        in_ready  = 1'b1;
        start_mul = in_ch.valid && cal_ok;
      end
      pms_pkg::ST_MUL: begin
        start_div = mul_x_sts.done && mul_y_sts.done;
      end
      pms_pkg::ST_DIV: ;
      pms_pkg::ST_DONE: begin
        load_out = !ovalid_r || out_ch.ready;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pms_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // latch calibration verdict and divisor with the request
  always_ff @(posedge clk) begin
    if (accept) begin
      badcal_r  <= !cal_ok;
      divisor_r <= divisor;
    end
  end

  pms_mul u_mul_x (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start_mul),
    .raw   (in_ch.raw_dx),
    .mult  (mult),
    .rem   (rem_x_r),
    .num   (num_x),
    .sts   (mul_x_sts)
  );

  pms_mul u_mul_y (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start_mul),
    .raw   (in_ch.raw_dy),
    .mult  (mult),
    .rem   (rem_y_r),
    .num   (num_y),
    .sts   (mul_y_sts)
  );

  pms_div u_div_x (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start_div),
    .num     (num_x),
    .divisor (divisor_r),
    .quot    (quot_x),
    .rem     (rem_x),
    .sts     (div_x_sts)
  );

  pms_div u_div_y (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start_div),
    .num     (num_y),
    .divisor (divisor_r),
    .quot    (quot_y),
    .rem     (rem_y),
    .sts     (div_y_sts)
  );

  // status: bad calibration first, then range, then zero motion, then the motion limit
  assign fit_x   = (&quot_x[pms_pkg::NUM_W-1:pms_pkg::OUT_W-1]) ||
                   !(|quot_x[pms_pkg::NUM_W-1:pms_pkg::OUT_W-1]);
  assign fit_y   = (&quot_y[pms_pkg::NUM_W-1:pms_pkg::OUT_W-1]) ||
                   !(|quot_y[pms_pkg::NUM_W-1:pms_pkg::OUT_W-1]);
  assign zero_xy = (quot_x == '0) && (quot_y == '0);
  assign mot_x   = (quot_x >= pms_pkg::MOTION_LO) && (quot_x <= pms_pkg::MOTION_HI);
  assign mot_y   = (quot_y >= pms_pkg::MOTION_LO) && (quot_y <= pms_pkg::MOTION_HI);

  always_comb begin
    priority if (badcal_r) begin
      status = pms_pkg::STAT_BADCAL;
    end else if (!fit_x || !fit_y) begin
      status = pms_pkg::STAT_RANGE;
    end else if (zero_xy) begin
      status = pms_pkg::STAT_ZERO;
    end else if (!mot_x || !mot_y) begin
      status = pms_pkg::STAT_INVALID;
    end else begin
      status = pms_pkg::STAT_MOTION;
    end
  end

  // carry remainders on every calibrated request, whatever its status
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_x_r <= '0;
      rem_y_r <= '0;
    end else if (load_out && !badcal_r) begin
      rem_x_r <= rem_x;
      rem_y_r <= rem_y;
    end
  end

  // output register: hold until taken, refill from the finished request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
    end else if (load_out) begin
      ovalid_r <= 1'b1;
    end else if (out_ch.ready) begin
      ovalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      ostatus_r <= status;
      odx_r     <= (status == pms_pkg::STAT_MOTION) ? quot_x[pms_pkg::OUT_W-1:0] : '0;
      ody_r     <= (status == pms_pkg::STAT_MOTION) ? quot_y[pms_pkg::OUT_W-1:0] : '0;
    end
  end

  assign in_ch.ready      = in_ready;
  assign out_ch.valid     = ovalid_r;
  assign out_ch.status    = ostatus_r;
  assign out_ch.scaled_dx = odx_r;
  assign out_ch.scaled_dy = ody_r;

endmodule

FILE: rtl/pms_mul.sv
module pms_mul (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  input  logic signed [pms_pkg::RAW_W-1:0]      raw,
  input  logic        [pms_pkg::MULT_W-1:0]     mult,
  input  logic signed [pms_pkg::REM_W-1:0]      rem,
  output logic signed [pms_pkg::NUM_W-1:0]      num,
  output pms_pkg::pms_unit_sts_t                sts
);

  localparam int CNT_W = $clog2(pms_pkg::MUL_STEPS + 1);

  logic                            busy_r, busy_nxt;
  logic                            done_r, done_nxt;
  logic [CNT_W-1:0]                cnt_r, cnt_nxt;
  logic [pms_pkg::RAW_W-1:0]       mag_r;
  logic [pms_pkg::ACC_W-1:0]       mcand_r;
  logic [pms_pkg::ACC_W-1:0]       acc_r;
  logic                            neg_r;
  logic signed [pms_pkg::NUM_W-1:0] num_r;

  logic [pms_pkg::RAW_W-1:0]       raw_u;
  logic                            last;
  logic signed [pms_pkg::NUM_W-1:0] acc_s;
  logic signed [pms_pkg::NUM_W-1:0] rem_ext;

  assign raw_u   = raw;
  assign last    = (cnt_r == CNT_W'(pms_pkg::MUL_STEPS));
  assign acc_s   = $signed({1'b0, acc_r});
  assign rem_ext = $signed({{(pms_pkg::NUM_W-pms_pkg::REM_W){rem[pms_pkg::REM_W-1]}}, rem});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = done_r;
    cnt_nxt  = cnt_r;
    if (start) begin
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
      cnt_nxt  = '0;
    end else if (busy_r && !last) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (busy_r) begin
      busy_nxt = 1'b0;
      done_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // shift-add over the magnitude of the raw count, one bit a cycle
  always_ff @(posedge clk) begin
    if (start) begin
      mag_r   <= raw_u[pms_pkg::RAW_W-1] ? pms_pkg::RAW_W'(~raw_u + pms_pkg::RAW_W'(1))
                                         : raw_u;
      mcand_r <= pms_pkg::ACC_W'(mult);
      acc_r   <= '0;
      neg_r   <= raw_u[pms_pkg::RAW_W-1];
    end else if (busy_r && !last) begin
      if (mag_r[0]) begin
        acc_r <= acc_r + mcand_r;
      end
      mcand_r <= {mcand_r[pms_pkg::ACC_W-2:0], 1'b0};
      mag_r   <= {1'b0, mag_r[pms_pkg::RAW_W-1:1]};
    end else if (busy_r) begin
      num_r <= (neg_r ? -acc_s : acc_s) + rem_ext;
    end
  end

  assign num      = num_r;
  assign sts.busy = busy_r;
  assign sts.done = done_r;

endmodule

FILE: rtl/pms_div.sv
module pms_div (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  input  logic signed [pms_pkg::NUM_W-1:0]      num,
  input  logic        [pms_pkg::DIV_W-1:0]      divisor,
  output logic signed [pms_pkg::NUM_W-1:0]      quot,
  output logic signed [pms_pkg::REM_W-1:0]      rem,
  output pms_pkg::pms_unit_sts_t                sts
);

  localparam int CNT_W = $clog2(pms_pkg::DIV_STEPS);

  logic                        busy_r, busy_nxt;
  logic                        done_r, done_nxt;
  logic [CNT_W-1:0]            cnt_r, cnt_nxt;
  logic [pms_pkg::MAG_W-1:0]   q_r;
  logic [pms_pkg::DIV_W-1:0]   pr_r;
  logic [pms_pkg::DIV_W-1:0]   d_r;
  logic                        neg_r;

  logic                             last;
  logic signed [pms_pkg::NUM_W-1:0] num_neg;
  logic [pms_pkg::DIV_W:0]          shifted;
  logic [pms_pkg::DIV_W:0]          diff;
  logic                             ge;
  logic signed [pms_pkg::NUM_W-1:0] q_ext;
  logic signed [pms_pkg::REM_W-1:0] r_ext;

  assign last    = (cnt_r == CNT_W'(pms_pkg::DIV_STEPS - 1));
  assign num_neg = -num;
  assign shifted = {pr_r, q_r[pms_pkg::MAG_W-1]};
  assign ge      = (shifted >= {1'b0, d_r});
  assign diff    = shifted - {1'b0, d_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = done_r;
    cnt_nxt  = cnt_r;
    if (start) begin
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
      cnt_nxt  = '0;
    end else if (busy_r) begin
      cnt_nxt = cnt_r + CNT_W'(1);
      if (last) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // restoring division of the magnitude, one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= num[pms_pkg::NUM_W-1] ? num_neg[pms_pkg::MAG_W-1:0] : num[pms_pkg::MAG_W-1:0];
      pr_r  <= '0;
      d_r   <= divisor;
      neg_r <= num[pms_pkg::NUM_W-1];
    end else if (busy_r) begin
      pr_r <= ge ? diff[pms_pkg::DIV_W-1:0] : shifted[pms_pkg::DIV_W-1:0];
      q_r  <= {q_r[pms_pkg::MAG_W-2:0], ge};
    end
  end

  // truncation toward zero: both results take the sign of the dividend
  assign q_ext    = $signed({1'b0, q_r});
  assign r_ext    = $signed({{(pms_pkg::REM_W-pms_pkg::DIV_W){1'b0}}, pr_r});
  assign quot     = neg_r ? -q_ext : q_ext;
  assign rem      = neg_r ? -r_ext : r_ext;
  assign sts.busy = busy_r;
  assign sts.done = done_r;

endmodule
